// ===== rtl/core/eil_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eil_pkg: shared types and constants of the ext4 inode locator
// Word layouts of both channels, configuration set, command word and codes.
// ----------------------------------------------------------------------------
package eil_pkg;

  localparam int MAX_GROUPS = 256;
  localparam int GROUP_W    = $clog2(MAX_GROUPS);
  localparam int DIV_STAGES = 32;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_INODE_ZERO = 2'd1;
  localparam logic [1:0] ERR_GROUP      = 2'd2;

  localparam logic MODE_WRITE     = 1'b0;
  localparam logic MODE_TRANSLATE = 1'b1;

  localparam logic [1:0] REG_GROUP_INODE_COUNT = 2'd0;
  localparam logic [1:0] REG_INODE_RECORD      = 2'd1;
  localparam logic [1:0] REG_LOG_BLOCK_SIZE    = 2'd2;
  localparam logic [1:0] REG_START_SECTOR      = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [7:0]  group_index;
    logic [31:0] table_block;
    logic [31:0] inode_number;
  } in_word_t;

  typedef struct packed {
    logic [63:0] sector;
    logic [15:0] byte_offset;
    logic [1:0]  error;
  } out_word_t;

  typedef struct packed {
    logic [31:0] group_inode_count;
    logic [10:0] inode_record_size;
    logic [2:0]  log_block_size;
    logic [47:0] start_sector;
  } cfg_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic        mode;
    logic [7:0]  group_index;
    logic [31:0] table_block;
    logic [31:0] n;
    logic [1:0]  err;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/eil_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eil_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module eil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/eil_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eil_front: input stage of the inode locator
// Accepts words, classifies trivial errors and forms the zero-based inode.
// ----------------------------------------------------------------------------
module eil_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire eil_pkg::in_word_t in_word,
  input  wire eil_pkg::cfg_t     cfg,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output eil_pkg::cmd_t          cmd
);
  import eil_pkg::*;

  logic valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    cmd_nxt.mode        = in_word.mode;
    cmd_nxt.group_index = in_word.group_index;
    cmd_nxt.table_block = in_word.table_block;
    cmd_nxt.n           = in_word.inode_number - 32'd1;
    if (in_word.mode == MODE_WRITE) begin
      cmd_nxt.err = (32'(in_word.group_index) >= 32'(MAX_GROUPS)) ? ERR_GROUP : ERR_OK;
    end else if (in_word.inode_number == 32'd0) begin
      cmd_nxt.err = ERR_INODE_ZERO;
    end else if (cfg.group_inode_count == 32'd0) begin
      cmd_nxt.err = ERR_GROUP;
    end else begin
      cmd_nxt.err = ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/eil_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eil_queue: two-entry command queue
// Decouples the front end from the back end so that each may stall alone.
// ----------------------------------------------------------------------------
module eil_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire eil_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output eil_pkg::cmd_t      pop_cmd
);
  import eil_pkg::*;

  cmd_t       slot_r [0:1];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/eil_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eil_back: execution pipeline of the inode locator
// Pipelined divider, group table, record scaling and sector arithmetic.
// ----------------------------------------------------------------------------
module eil_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire eil_pkg::cmd_t cmd,
  input  wire eil_pkg::cfg_t cfg,
  output logic               out_valid,
  input  wire logic          out_ready,
  output eil_pkg::out_word_t out_word
);
  import eil_pkg::*;

  logic en;

  // Divider stages: index 0 is loaded from the queue, index DIV_STAGES is done.
  logic        dv_valid_r [0:DIV_STAGES];
  cmd_t        dv_cmd_r   [0:DIV_STAGES];
  logic [31:0] dv_rem_r   [0:DIV_STAGES];
  logic [31:0] dv_dvd_r   [0:DIV_STAGES];
  logic [31:0] dv_quo_r   [0:DIV_STAGES];
  logic [31:0] dv_rem_nxt [0:DIV_STAGES-1];
  logic [31:0] dv_quo_nxt [0:DIV_STAGES-1];

  // Lookup and scaling stage.
  logic                  m_valid_r;
  logic                  m_mode_r;
  logic [1:0]            m_err_r;
  logic                  m_oor_r;
  logic                  m_loaded_r;
  logic [42:0]           m_prod_r;
  logic [31:0]           m_tstart;
  logic [MAX_GROUPS-1:0] loaded_r;

  // Block split stage.
  logic        n_valid_r;
  logic [1:0]  n_err_r;
  logic [33:0] n_sum_r;
  logic [15:0] n_inblk_r;
  logic [1:0]  n_err_nxt;
  logic        n_zero_r;
  logic [2:0]  lg;
  logic [4:0]  bshift;
  logic [42:0] blk_off;
  logic [15:0] in_blk;

  logic      o_valid_r;
  out_word_t o_word_r;
  logic [63:0] sector_nxt;

  logic               tbl_we;
  logic [GROUP_W-1:0] tbl_waddr;
  logic [GROUP_W-1:0] tbl_raddr;
  logic [31:0]        quo_l;
  cmd_t               cmd_l;

  assign en        = !o_valid_r || out_ready;
  assign cmd_ready = en;
  assign out_valid = o_valid_r;
  assign out_word  = o_word_r;

  // One restoring division step per stage.
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      logic [32:0] trial;
      trial = {dv_rem_r[k], dv_dvd_r[k][31]};
      if (trial >= {1'b0, cfg.group_inode_count}) begin
        dv_rem_nxt[k] = 32'(trial - {1'b0, cfg.group_inode_count});
        dv_quo_nxt[k] = {dv_quo_r[k][30:0], 1'b1};
      end else begin
        dv_rem_nxt[k] = trial[31:0];
        dv_quo_nxt[k] = {dv_quo_r[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dv_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      dv_valid_r[0] <= cmd_valid;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
    end
    if (en) begin
      dv_cmd_r[0] <= cmd;
      dv_rem_r[0] <= 32'd0;
      dv_dvd_r[0] <= cmd.n;
      dv_quo_r[0] <= 32'd0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_cmd_r[k+1] <= dv_cmd_r[k];
        dv_rem_r[k+1] <= dv_rem_nxt[k];
        dv_dvd_r[k+1] <= {dv_dvd_r[k][30:0], 1'b0};
        dv_quo_r[k+1] <= dv_quo_nxt[k];
      end
    end
  end

  assign quo_l     = dv_quo_r[DIV_STAGES];
  assign cmd_l     = dv_cmd_r[DIV_STAGES];
  assign tbl_we    = en && dv_valid_r[DIV_STAGES] && (cmd_l.mode == MODE_WRITE)
                     && (cmd_l.err == ERR_OK);
  assign tbl_waddr = GROUP_W'(cmd_l.group_index);
  assign tbl_raddr = quo_l[GROUP_W-1:0];

  eil_ram #(.WIDTH(32), .DEPTH(MAX_GROUPS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (cmd_l.table_block),
    .re    (en),
    .raddr (tbl_raddr),
    .rdata (m_tstart)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= '0;
      m_valid_r <= 1'b0;
    end else begin
      if (tbl_we) begin
        loaded_r[tbl_waddr] <= 1'b1;
      end
      if (en) begin
        m_valid_r <= dv_valid_r[DIV_STAGES];
      end
    end
    if (en) begin
      m_mode_r   <= cmd_l.mode;
      m_err_r    <= cmd_l.err;
      m_oor_r    <= (quo_l >= 32'(MAX_GROUPS));
      m_loaded_r <= loaded_r[tbl_raddr];
      m_prod_r   <= 43'(dv_rem_r[DIV_STAGES]) * 43'(cfg.inode_record_size);
    end
  end

  assign lg      = (cfg.log_block_size > 3'd6) ? 3'd6 : cfg.log_block_size;
  assign bshift  = 5'd10 + 5'(lg);
  assign blk_off = m_prod_r >> bshift;
  assign in_blk  = 16'(m_prod_r & ((43'd1 << bshift) - 43'd1));

  always_comb begin
    if (m_err_r != ERR_OK) begin
      n_err_nxt = m_err_r;
    end else if ((m_mode_r == MODE_TRANSLATE) && (m_oor_r || !m_loaded_r)) begin
      n_err_nxt = ERR_GROUP;
    end else begin
      n_err_nxt = ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_valid_r <= 1'b0;
    end else if (en) begin
      n_valid_r <= m_valid_r;
    end
    if (en) begin
      n_err_r <= n_err_nxt;
      if ((n_err_nxt == ERR_OK) && (m_mode_r == MODE_TRANSLATE)) begin
        n_sum_r   <= 34'(m_tstart) + 34'(blk_off);
        n_inblk_r <= in_blk;
      end else begin
        n_sum_r   <= 34'd0;
        n_inblk_r <= 16'd0;
      end
    end
  end

  always_comb begin
    if (n_sum_r == 34'd0 && n_inblk_r == 16'd0 && n_err_r != ERR_OK) begin
      sector_nxt = 64'd0;
    end else if (n_sum_r == 34'd0 && n_inblk_r == 16'd0 && !n_valid_r) begin
      sector_nxt = 64'd0;
    end else begin
      sector_nxt = 64'(cfg.start_sector) + (64'(n_sum_r) << (4'd1 + 4'(lg)));
    end
  end

  // Writes and errors carry zero sum, but the sector still needs forcing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (en) begin
      o_valid_r <= n_valid_r;
    end
    if (en) begin
      o_word_r.error       <= n_err_r;
      o_word_r.byte_offset <= n_inblk_r;
      o_word_r.sector      <= (n_err_r != ERR_OK || n_zero_r) ? 64'd0 : sector_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_zero_r <= (m_mode_r == MODE_WRITE);
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_word_r.error != ERR_OK) |->
    (o_word_r.sector == 64'd0 && o_word_r.byte_offset == 16'd0))
    else $error("error result carries a non-zero location");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> (o_word_r.error != 2'd3)) else $error("undefined error code");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> (!m_valid_r || $stable(m_prod_r)) && (!n_valid_r || $stable(n_sum_r)))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ext4_inode_locator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ext4_inode_locator: ext4 inode sector and offset calculator
// Holds per-group inode table starts and translates inode numbers to sectors.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the result side does not
// stall and returns one word per word taken, in order. A word in write mode
// stores the inode table start block of a block group; a word in translate
// mode returns the first sector of the block holding the inode and its byte
// offset within that block. On its way to the result a word passes the input
// register, the command queue, the pipelined divider (a load stage and 32
// one-bit steps) that splits the inode number into a group and an index, and
// then the table read with the record scaling multiply, the block split and
// the sector sum in the output register. Writes travel the same pipeline, so
// a translation that follows a write always sees it. When the result side
// stalls the whole back end holds, while the two-entry queue and the input
// register let the input side take up to three further words.
// Configuration registers are written through the plain write port and must
// only be changed while the block is idle.
// ----------------------------------------------------------------------------
module ext4_inode_locator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire eil_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output eil_pkg::out_word_t      out_word,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_wdata
);
  import eil_pkg::*;

  cfg_t cfg_r;
  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic b_valid;
  logic b_ready;
  cmd_t b_cmd;

  // Configuration registers, loaded with the usual 4 KiB block layout.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_inode_count <= 32'd8192;
      cfg_r.inode_record_size <= 11'd256;
      cfg_r.log_block_size    <= 3'd2;
      cfg_r.start_sector      <= 48'h104000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_INODE_COUNT: cfg_r.group_inode_count <= cfg_wdata[31:0];
        REG_INODE_RECORD:      cfg_r.inode_record_size <= cfg_wdata[10:0];
        REG_LOG_BLOCK_SIZE:    cfg_r.log_block_size    <= cfg_wdata[2:0];
        REG_START_SECTOR:      cfg_r.start_sector      <= cfg_wdata;
        default:               cfg_r.start_sector      <= cfg_r.start_sector;
      endcase
    end
  end

  // The front end classifies each word and forms the zero-based inode.
  eil_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cfg       (cfg_r),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  eil_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  // The back end divides, looks up the group and computes the location.
  eil_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// ===== tb/inode_location_checker.sv =====
// ----------------------------------------------------------------------------
// inode_location_checker: result predictor and comparator
// Watches both channels of the inode locator, forecasts each result word from
// its own copy of the group table and configuration, and counts mismatches.
// ----------------------------------------------------------------------------
module inode_location_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  eil_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  eil_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);
  import eil_pkg::*;

  cfg_t        shadow_cfg;
  logic [31:0] table_start [MAX_GROUPS];
  logic        group_valid [MAX_GROUPS];
  out_word_t   expected_locations [$];

  function automatic out_word_t locate_inode(in_word_t w);
    out_word_t   r;
    logic [63:0] n, grp, idx, pos, blk;
    logic [2:0]  lg;
    r = '0;
    if (w.mode == MODE_WRITE) begin
      r.error = ERR_OK;
      return r;
    end
    if (w.inode_number == 0) begin
      r.error = ERR_INODE_ZERO;
      return r;
    end
    if (shadow_cfg.group_inode_count == 0) begin
      r.error = ERR_GROUP;
      return r;
    end
    n   = 64'(w.inode_number) - 1;
    grp = n / shadow_cfg.group_inode_count;
    idx = n % shadow_cfg.group_inode_count;
    if (grp >= MAX_GROUPS || !group_valid[grp[7:0]]) begin
      r.error = ERR_GROUP;
      return r;
    end
    lg  = (shadow_cfg.log_block_size > 6) ? 3'd6 : shadow_cfg.log_block_size;
    pos = idx * shadow_cfg.inode_record_size;
    blk = pos >> (10 + lg);
    r.byte_offset = 16'(pos & ((64'd1 << (10 + lg)) - 1));
    r.sector = 64'(shadow_cfg.start_sector)
             + (64'(table_start[grp[7:0]]) + blk) * (64'd2 << lg);
    r.error = ERR_OK;
    return r;
  endfunction

  assign pending_count = expected_locations.size();

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      shadow_cfg <= '{32'd8192, 11'd256, 3'd2, 48'd1064960};
      for (int g = 0; g < MAX_GROUPS; g++) group_valid[g] = 1'b0;
      expected_locations.delete();
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GROUP_INODE_COUNT: shadow_cfg.group_inode_count <= cfg_wdata[31:0];
          REG_INODE_RECORD:      shadow_cfg.inode_record_size <= cfg_wdata[10:0];
          REG_LOG_BLOCK_SIZE:    shadow_cfg.log_block_size    <= cfg_wdata[2:0];
          default:               shadow_cfg.start_sector      <= cfg_wdata;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_locations.push_back(locate_inode(in_word));
        if (in_word.mode == MODE_WRITE) begin
          table_start[in_word.group_index] = in_word.table_block;
          group_valid[in_word.group_index] = 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_locations.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result word with nothing expected: %p",
                                        out_word);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_locations.pop_front();
          if (e !== out_word) begin
            if (fail_count < 10)
              $display("ERROR: sector %h/%h offset %h/%h error %0d/%0d (exp/act)",
                       e.sector, out_word.sector, e.byte_offset, out_word.byte_offset,
                       e.error, out_word.error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_ext4_inode_locator.sv =====
// ----------------------------------------------------------------------------
// tb_ext4_inode_locator: testbench of the ext4 inode locator
// Loads group tables and translates inodes under several configurations,
// with random gaps on both channels; the checker judges every result word.
// ----------------------------------------------------------------------------
module tb_ext4_inode_locator;
  import eil_pkg::*;

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_word_t  in_word;
  out_word_t out_word;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_wdata;
  int        fail_count, pending_count, result_count;
  int        cycle_count;
  int        words_sent;

  // The latency of the block bounds the settling time after the last result.
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 400000;

  ext4_inode_locator u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_word,
    .out_valid, .out_ready, .out_word, .cfg_we, .cfg_index, .cfg_wdata
  );

  inode_location_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_word,
    .out_valid, .out_ready, .out_word, .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .pending_count, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: any hang in either handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Before each word the receiver stalls for a random number of cycles or, for
  // about one word in four, not at all.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // One register write, only ever issued while the block is idle.
  task automatic write_register(input logic [1:0] idx, input logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Presents one word, keeping valid high until it is taken. Gaps come first,
  // so valid never drops between back-to-back words within one step.
  task automatic send_word(input in_word_t w, input bit use_gap);
    int gap;
    gap = use_gap ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_word_t table_load(input logic [7:0] grp, input logic [31:0] blk);
    in_word_t w;
    w = '0;
    w.mode = MODE_WRITE;
    w.group_index = grp;
    w.table_block = blk;
    w.inode_number = $urandom();
    return w;
  endfunction

  function automatic in_word_t inode_lookup(input logic [31:0] ino);
    in_word_t w;
    w = '0;
    w.mode = MODE_TRANSLATE;
    w.group_index = $urandom();
    w.table_block = $urandom();
    w.inode_number = ino;
    return w;
  endfunction

  // Picks an inode number that mostly lands in a small, probably loaded group.
  function automatic logic [31:0] pick_inode(input logic [31:0] ipg);
    logic [63:0] grp;
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'd0;
      default: begin
        grp = $urandom_range(0, 20);
        return 32'((grp * ipg + $urandom_range(0, 1) * (ipg - 1) % 64'd4294967295)
                   + $urandom_range(1, (ipg > 1) ? ((ipg > 4000) ? 4000 : ipg) : 1));
      end
    endcase
  endfunction

  initial begin
    logic [31:0] ipg;
    int          phase;
    in_valid   = 1'b0;
    in_word    = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_GROUP_INODE_COUNT;
    cfg_wdata  = '0;
    words_sent = 0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset configuration: lookups of unloaded groups,
    // inode zero, extreme table blocks and the last inode of a group.
    send_word(inode_lookup(32'd1), 1'b0);
    send_word(inode_lookup(32'd0), 1'b0);
    send_word(table_load(8'd0, 32'hFFFF_FFFF), 1'b0);
    send_word(table_load(8'd255, 32'd0), 1'b0);
    send_word(table_load(8'd1, 32'd1234), 1'b1);
    send_word(inode_lookup(32'd1), 1'b0);
    send_word(inode_lookup(32'd8192), 1'b0);
    send_word(inode_lookup(32'd8193), 1'b0);
    send_word(inode_lookup(32'd8192 * 255 + 1), 1'b0);
    send_word(inode_lookup(32'd8192 * 256 + 1), 1'b1);
    send_word(inode_lookup(32'hFFFF_FFFF), 1'b0);
    send_word(inode_lookup(32'd3), 1'b0);
    drain_block();

    // Extreme settings: one inode per group, a record of 1024 bytes, block size
    // code seven and the largest start sector.
    write_register(REG_GROUP_INODE_COUNT, 48'd1);
    write_register(REG_INODE_RECORD, 48'd1024);
    write_register(REG_LOG_BLOCK_SIZE, 48'd7);
    write_register(REG_START_SECTOR, 48'hFFFF_FFFF_FFFF);
    send_word(inode_lookup(32'd1), 1'b0);
    send_word(inode_lookup(32'd256), 1'b0);
    send_word(inode_lookup(32'd257), 1'b0);
    drain_block();
    write_register(REG_GROUP_INODE_COUNT, 48'hFFFF_FFFF);
    write_register(REG_INODE_RECORD, 48'd0);
    write_register(REG_LOG_BLOCK_SIZE, 48'd0);
    write_register(REG_START_SECTOR, 48'd0);
    send_word(inode_lookup(32'hFFFF_FFFF), 1'b0);
    send_word(inode_lookup(32'd2), 1'b0);
    drain_block();
    write_register(REG_GROUP_INODE_COUNT, 48'd0);
    write_register(REG_INODE_RECORD, 48'd2047);
    send_word(inode_lookup(32'd5), 1'b0);
    send_word(inode_lookup(32'd0), 1'b0);
    drain_block();

    // Random phases: each picks a configuration, mostly loads tables and
    // translates inodes that fall into them, with some stray words mixed in.
    for (phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 3))
        0:       ipg = $urandom_range(1, 16);
        1:       ipg = $urandom_range(1, 70000);
        2:       ipg = $urandom();
        default: ipg = 32'd8192;
      endcase
      write_register(REG_GROUP_INODE_COUNT, 48'(ipg));
      write_register(REG_INODE_RECORD, ($urandom_range(0, 4) == 0)
                     ? 48'($urandom_range(0, 2047)) : 48'($urandom_range(128, 1024)));
      write_register(REG_LOG_BLOCK_SIZE, 48'($urandom_range(0, 7)));
      write_register(REG_START_SECTOR, {$urandom(), 16'($urandom())});
      repeat (130) begin
        if ($urandom_range(0, 3) == 0)
          send_word(table_load(($urandom_range(0, 5) == 0) ? 8'($urandom())
                                                           : 8'($urandom_range(0, 20)),
                               $urandom()), $urandom_range(0, 2) != 0);
        else
          send_word(inode_lookup(pick_inode(ipg)), $urandom_range(0, 2) != 0);
      end
      drain_block();
    end

    $display("Summary: %0d words sent, %0d result words checked over 14 settings.",
             words_sent, result_count);
    $display("Loads, lookups, inode zero, unloaded and out-of-range groups covered.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/eil_pkg.sv
rtl/core/eil_ram.sv
rtl/core/eil_front.sv
rtl/core/eil_queue.sv
rtl/core/eil_back.sv
rtl/core/ext4_inode_locator.sv
tb/inode_location_checker.sv
tb/tb_ext4_inode_locator.sv
